### sv/swerm_pkg.sv
// shared constants and types of the sliding window event rate meter
package swerm_pkg;

    // timestamp and rate widths
    localparam int TIME_W = 64;
    localparam int RATE_W = 32;

    // ring of timestamps, the window holds at most RING_DEPTH-1 events
    localparam int RING_DEPTH = 16;
    localparam int PTR_W = $clog2(RING_DEPTH);

    // events per second in q8 for a millisecond time base
    localparam int RATE_SCALE = 256000;
    localparam int NUM_MAX = RATE_SCALE * (RING_DEPTH - 1);
    localparam int NUM_W = $clog2(NUM_MAX + 1);
    localparam int STEP_W = $clog2(NUM_W + 1);

    localparam logic [RATE_W-1:0] RATE_SAT = {RATE_W{1'b1}};

    // divider status seen by the sequencer
    typedef struct packed {
        logic busy;
        logic done;
    } t_div_status;

endpackage

### sv/swerm_if.sv
// event and rate channels of the sliding window event rate meter

// event channel: one timestamp per transaction
interface swerm_event_if;
    import swerm_pkg::*;

    logic              valid;
    logic              ready;
    logic [TIME_W-1:0] event_time_ms;

    modport source (output valid, output event_time_ms, input ready);
    modport sink (input valid, input event_time_ms, output ready);
endinterface

// rate channel: one rate result per transaction
interface swerm_rate_if;
    import swerm_pkg::*;

    logic              valid;
    logic              ready;
    logic [RATE_W-1:0] rate_q8;
    logic              rate_valid;

    modport source (output valid, output rate_q8, output rate_valid, input ready);
    modport sink (input valid, input rate_q8, input rate_valid, output ready);
endinterface

### sv/swerm_div.sv
// restoring divider, one quotient bit per cycle
module swerm_div (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [swerm_pkg::NUM_W-1:0] i_num,
    input  logic [swerm_pkg::TIME_W-1:0] i_den,
    output swerm_pkg::t_div_status      o_status,
    output logic [swerm_pkg::NUM_W-1:0] o_quot
);
    import swerm_pkg::*;

    logic              r_busy;
    logic              r_done;
    logic [STEP_W-1:0] r_cnt;
    logic [NUM_W-1:0]  r_rem;
    logic [NUM_W-1:0]  r_work;
    logic [TIME_W-1:0] r_den;

    logic [NUM_W:0]    w_shift;
    logic              w_fits;
    logic [TIME_W-1:0] w_diff;
    logic [NUM_W-1:0]  n_rem;

    // trial subtract of the shifted partial remainder
    assign w_shift = {r_rem, r_work[NUM_W-1]};
    assign w_fits  = (TIME_W'(w_shift) >= r_den);
    assign w_diff  = TIME_W'(w_shift) - r_den;
    assign n_rem   = w_fits ? w_diff[NUM_W-1:0] : w_shift[NUM_W-1:0];

    // control of the iteration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= STEP_W'(NUM_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - STEP_W'(1);
                if (r_cnt == STEP_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // numerator bits shift out the top, quotient bits in at the bottom
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem  <= '0;
            r_work <= i_num;
            r_den  <= i_den;
        end else if (r_busy) begin
            r_rem  <= n_rem;
            r_work <= {r_work[NUM_W-2:0], w_fits};
        end
    end

    assign o_status.busy = r_busy;
    assign o_status.done = r_done;
    assign o_quot        = r_work;

endmodule

### sv/sliding_window_event_rate_meter.sv
// top level: timestamp ring, sequencer and output register of the rate meter
//
//  channel   | dir | interface      | payload
//  i_event   | in  | swerm_event_if | event_time_ms[63:0]
//  o_rate    | out | swerm_rate_if  | rate_q8[31:0], rate_valid
//
// an event skips the divider when fewer than two events are held or the time
// difference is zero; otherwise its rate comes from the restoring divider,
// which yields one quotient bit per cycle.
// the next event is taken in the cycle after the result enters the output
// register; a stalled output holds the sequencer in its final state.
// synchronous active low reset clears pointers, count and control only.
module sliding_window_event_rate_meter (
    input  logic                i_clk,
    input  logic                i_rst_n,
    swerm_event_if.sink         i_event,
    swerm_rate_if.source        o_rate
);
    import swerm_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_CALC,
        S_DIV,
        S_DONE
    } t_state;

    localparam logic [PTR_W-1:0] HELD_MAX     = PTR_W'(RING_DEPTH - 1);
    localparam logic [NUM_W-1:0] RATE_SCALE_N = NUM_W'(RATE_SCALE);

    // wrap a ring pointer
    function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
        logic [PTR_W-1:0] r;
        r = (p == HELD_MAX) ? '0 : p + PTR_W'(1);
        return r;
    endfunction

    t_state            r_state, n_state;
    logic [PTR_W-1:0]  r_wp, n_wp;
    logic [PTR_W-1:0]  r_oldest, n_oldest;
    logic [PTR_W-1:0]  r_held, n_held;
    logic [TIME_W-1:0] r_now, n_now;
    logic [NUM_W-1:0]  r_num, n_num;
    logic [TIME_W-1:0] r_den, n_den;
    logic              r_div_start, n_div_start;
    logic [RATE_W-1:0] r_res_rate, n_res_rate;
    logic              r_res_valid, n_res_valid;
    logic              r_out_valid, n_out_valid;
    logic [RATE_W-1:0] r_out_rate, n_out_rate;
    logic              r_out_rv, n_out_rv;

    logic [TIME_W-1:0] r_time_ring [RING_DEPTH];
    logic [TIME_W-1:0] r_rdata;

    logic              w_event_accept;
    logic              w_out_free;
    logic [TIME_W-1:0] w_diff;
    t_div_status       w_div_status;
    logic [NUM_W-1:0]  w_quot;

    assign w_event_accept = i_event.valid && i_event.ready;
    assign w_out_free     = !r_out_valid || o_rate.ready;
    assign w_diff         = r_now - r_rdata;

    // timestamp ring, read of the oldest entry registered
    always_ff @(posedge i_clk) begin
        if (w_event_accept) begin
            r_time_ring[r_wp] <= i_event.event_time_ms;
        end
        r_rdata <= r_time_ring[r_oldest];
    end

    // restoring divider, started by the sequencer
    swerm_div u_div (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (r_div_start),
        .i_num    (r_num),
        .i_den    (r_den),
        .o_status (w_div_status),
        .o_quot   (w_quot)
    );

    // sequencer next state
    always_comb begin
        n_state     = r_state;
        n_wp        = r_wp;
        n_oldest    = r_oldest;
        n_held      = r_held;
        n_now       = r_now;
        n_num       = r_num;
        n_den       = r_den;
        n_div_start = 1'b0;
        n_res_rate  = r_res_rate;
        n_res_valid = r_res_valid;
        n_out_valid = r_out_valid;
        n_out_rate  = r_out_rate;
        n_out_rv    = r_out_rv;

        // output transaction frees the register
        if (o_rate.valid && o_rate.ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (w_event_accept) begin
                    n_now = i_event.event_time_ms;
                    n_wp  = ptr_next(r_wp);
                    if (r_held == HELD_MAX) begin
                        n_oldest = ptr_next(r_oldest);
                    end else begin
                        n_held = r_held + PTR_W'(1);
                    end
                    n_state = S_READ;
                end
            end
            S_READ: begin
                n_state = S_CALC;
            end
            S_CALC: begin
                if (r_held < PTR_W'(2)) begin
                    n_res_rate  = '0;
                    n_res_valid = 1'b0;
                    n_state     = S_DONE;
                end else if (w_diff == '0) begin
                    n_res_rate  = RATE_SAT;
                    n_res_valid = 1'b1;
                    n_state     = S_DONE;
                end else begin
                    n_den       = w_diff;
                    n_num       = NUM_W'(RATE_SCALE_N * NUM_W'(r_held - PTR_W'(1)));
                    n_div_start = 1'b1;
                    n_state     = S_DIV;
                end
            end
            S_DIV: begin
                if (w_div_status.done) begin
                    n_res_rate  = RATE_W'(w_quot);
                    n_res_valid = 1'b1;
                    n_state     = S_DONE;
                end
            end
            S_DONE: begin
                if (w_out_free) begin
                    n_out_valid = 1'b1;
                    n_out_rate  = r_res_rate;
                    n_out_rv    = r_res_valid;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // state and registered outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_wp        <= '0;
            r_oldest    <= '0;
            r_held      <= '0;
            r_div_start <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_wp        <= n_wp;
            r_oldest    <= n_oldest;
            r_held      <= n_held;
            r_div_start <= n_div_start;
            r_out_valid <= n_out_valid;
        end
        r_now       <= n_now;
        r_num       <= n_num;
        r_den       <= n_den;
        r_res_rate  <= n_res_rate;
        r_res_valid <= n_res_valid;
        r_out_rate  <= n_out_rate;
        r_out_rv    <= n_out_rv;
    end

    assign i_event.ready     = (r_state == S_IDLE);
    assign o_rate.valid      = r_out_valid;
    assign o_rate.rate_q8    = r_out_rate;
    assign o_rate.rate_valid = r_out_rv;

`ifndef SYNTHESIS
    // divider only runs while the sequencer waits on it
    a_div_owned: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_status.busy |-> r_state == S_DIV)
        else $error("divider busy outside its sequencer state");

    // write pointer leads the oldest pointer by the held count
    a_ptr_span: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((PTR_W+1)'(r_oldest) + (PTR_W+1)'(r_held) == (PTR_W+1)'(r_wp)) ||
        ((PTR_W+1)'(r_oldest) + (PTR_W+1)'(r_held) ==
         (PTR_W+1)'(r_wp) + (PTR_W+1)'(RING_DEPTH)))
        else $error("ring pointers disagree with held count");

    // a result without a window carries a zero rate
    a_zero_rate: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rate.valid && !o_rate.rate_valid) |-> o_rate.rate_q8 == '0)
        else $error("nonzero rate without a valid window");

    // an accepted event always moves the write pointer
    a_wp_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_event_accept |=> r_wp != $past(r_wp))
        else $error("write pointer did not advance on an event");
`endif

endmodule
